### hdl/priority_round_robin_scheduler_assert.svh
// Assertion macros for the priority round robin scheduler.
`ifndef PRIORITY_ROUND_ROBIN_SCHEDULER_ASSERT_SVH
`define PRIORITY_ROUND_ROBIN_SCHEDULER_ASSERT_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define PRRS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define PRRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/prrs_pkg.sv
// Types and operation codes shared by the scheduler files.
`default_nettype none
package prrs_pkg;

  localparam logic [2:0] FUNC_ADD    = 3'd0;
  localparam logic [2:0] FUNC_REMOVE = 3'd1;
  localparam logic [2:0] FUNC_SETPRI = 3'd2;
  localparam logic [2:0] FUNC_ROTATE = 3'd3;
  localparam logic [2:0] FUNC_QUERY  = 3'd4;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] task_id;
    logic [4:0]  priority_req;
  } in_t;

  typedef struct packed {
    logic        status;
    logic        has_current;
    logic [63:0] current_id;
  } out_t;

  typedef struct packed {
    logic [63:0] id;
    logic [4:0]  prio;
    logic [63:0] stamp;
  } slot_t;

endpackage
`default_nettype wire

### hdl/priority_round_robin_scheduler.sv
// Top level of the priority round robin task scheduler.
`default_nettype none
// The scheduler keeps SLOTS task slots (id, priority, order stamp) in one
// synchronous RAM, with the active bits in flip-flops that reset clears. Each
// transaction on the input channel is one operation: add, remove, set
// priority, rotate or query. The block walks the RAM twice per operation:
// the first pass finds the slot holding the requested id, the lowest free
// slot and the current best task; the apply state then writes the modified
// entry back or clears its active bit; the second pass finds the best task
// after the change. Each pass issues one read a cycle through the single
// RAM read port. The next operation can be taken in the cycle after the
// result is posted. A result that waits on the output holds the block in
// its final state and thus stalls the next operation. One operation is in
// flight at a time; a new one may be accepted while the previous result
// still waits on the output. The best task is the lowest priority value,
// then the oldest stamp, then the lowest slot. Configuration writes
// (scheduler enable) are accepted on every cycle; no clearing pass is
// needed after reset, since inactive slots are never looked at.
module priority_round_robin_scheduler
  import prrs_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic cfg_scheduler_enable
);

  `include "priority_round_robin_scheduler_assert.svh"

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam logic [IW:0]   SLOTS_W  = (IW + 1)'(SLOTS);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN1 = 5'b00010,
    ST_APPLY = 5'b00100,
    ST_SCAN2 = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t          state_r;
  logic            enable_r;
  in_t             op_r;
  logic [SLOTS-1:0] active_r;
  logic [63:0]     stamp_ctr_r;
  logic [IW:0]     issue_cnt_r;
  logic            rd_vld_r;
  logic [IW-1:0]   rd_idx_r;
  logic            fail_r;
  logic            out_valid_r;
  out_t            out_data_r;

  // Trackers filled during a pass.
  logic            best_found_r;
  logic [IW-1:0]   best_idx_r;
  slot_t           best_r;
  logic            match_found_r;
  logic [IW-1:0]   match_idx_r;
  slot_t           match_r;
  logic            free_found_r;
  logic [IW-1:0]   free_idx_r;

  slot_t           rd_slot;
  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  slot_t           ram_wdata;
  logic            scanning;
  logic            issuing;
  logic            cand;
  logic            better;
  logic            last_rd;
  logic            op_ok;
  logic            ctr_inc;
  logic            act_set;
  logic            act_clr;
  logic [IW-1:0]   act_idx;

  prrs_ram #(
    .WIDTH($bits(slot_t)),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(issue_cnt_r[IW-1:0]),
    .rdata(rd_slot)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign scanning = (state_r == ST_SCAN1) || (state_r == ST_SCAN2);
  assign issuing  = scanning && (issue_cnt_r < SLOTS_W);
  assign last_rd  = rd_vld_r && (rd_idx_r == LAST_IDX);
  assign cand     = rd_vld_r && active_r[rd_idx_r];
  assign better   = !best_found_r || (rd_slot.prio < best_r.prio) ||
                    ((rd_slot.prio == best_r.prio) && (rd_slot.stamp < best_r.stamp));

  // Decide the outcome of the operation once the first pass is complete.
  always_comb begin
    op_ok     = 1'b0;
    ctr_inc   = 1'b0;
    act_set   = 1'b0;
    act_clr   = 1'b0;
    act_idx   = free_idx_r;
    ram_we    = 1'b0;
    ram_waddr = free_idx_r;
    ram_wdata = '{id: op_r.task_id, prio: op_r.priority_req, stamp: stamp_ctr_r};
    case (op_r.func)
      FUNC_ADD: begin
        op_ok = enable_r && (op_r.task_id != 64'd0) && !match_found_r && free_found_r;
        ctr_inc = op_ok;
        act_set = op_ok;
        ram_we  = op_ok;
      end
      FUNC_REMOVE: begin
        op_ok   = match_found_r;
        act_clr = op_ok;
        act_idx = match_idx_r;
      end
      FUNC_SETPRI: begin
        op_ok     = match_found_r;
        ram_we    = op_ok;
        ram_waddr = match_idx_r;
        ram_wdata = '{id: match_r.id, prio: op_r.priority_req, stamp: match_r.stamp};
      end
      FUNC_ROTATE: begin
        op_ok     = enable_r && best_found_r;
        ctr_inc   = op_ok;
        ram_we    = op_ok;
        ram_waddr = best_idx_r;
        ram_wdata = '{id: best_r.id, prio: best_r.prio, stamp: stamp_ctr_r};
      end
      FUNC_QUERY: begin
        op_ok = best_found_r;
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
    if (state_r != ST_APPLY) begin
      ram_we  = 1'b0;
      ctr_inc = 1'b0;
      act_set = 1'b0;
      act_clr = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      enable_r    <= 1'b1;
      active_r    <= '0;
      stamp_ctr_r <= 64'd0;
      issue_cnt_r <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      best_found_r  <= 1'b0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        enable_r <= cfg_scheduler_enable;
      end
      // In the final state the result register is reloaded instead.
      if (out_valid_r && out_ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      rd_vld_r <= issuing;
      rd_idx_r <= issue_cnt_r[IW-1:0];
      if (issuing) begin
        issue_cnt_r <= issue_cnt_r + 1'b1;
      end
      if (ctr_inc) begin
        stamp_ctr_r <= stamp_ctr_r + 64'd1;
      end
      if (act_set) begin
        active_r[act_idx] <= 1'b1;
      end
      if (act_clr) begin
        active_r[act_idx] <= 1'b0;
      end

      // Compare unit shared by both passes.
      if (scanning && cand && better) begin
        best_found_r <= 1'b1;
        best_idx_r   <= rd_idx_r;
        best_r       <= rd_slot;
      end
      if ((state_r == ST_SCAN1) && cand && !match_found_r &&
          (rd_slot.id == op_r.task_id)) begin
        match_found_r <= 1'b1;
        match_idx_r   <= rd_idx_r;
        match_r       <= rd_slot;
      end
      if ((state_r == ST_SCAN1) && rd_vld_r && !active_r[rd_idx_r] && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= rd_idx_r;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            op_r          <= in_data;
            issue_cnt_r   <= '0;
            best_found_r  <= 1'b0;
            match_found_r <= 1'b0;
            free_found_r  <= 1'b0;
            state_r       <= ST_SCAN1;
          end
        end
        ST_SCAN1: begin
          if (last_rd) begin
            state_r <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          fail_r       <= !op_ok;
          issue_cnt_r  <= '0;
          best_found_r <= 1'b0;
          state_r      <= ST_SCAN2;
        end
        ST_SCAN2: begin
          if (last_rd) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r            <= 1'b1;
            out_data_r.status      <= fail_r;
            out_data_r.has_current <= best_found_r;
            out_data_r.current_id  <= best_found_r ? best_r.id : 64'd0;
            state_r                <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  `PRRS_ASSERT_SAME(a_we_only_apply, ram_we, state_r == ST_APPLY, "RAM written outside apply")
  `PRRS_ASSERT_NEXT(a_active_only_apply, state_r != ST_APPLY, active_r == $past(active_r),
    "active bits changed outside apply")
  `PRRS_ASSERT_NEXT(a_ctr_step, ctr_inc, stamp_ctr_r == $past(stamp_ctr_r) + 64'd1,
    "stamp counter did not advance by one")
  `PRRS_ASSERT_SAME(a_cur_nonzero, out_valid_r && out_data_r.has_current,
    out_data_r.current_id != 64'd0, "current task reported with zero id")

endmodule
`default_nettype wire

### hdl/prrs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module prrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for the priority round robin task scheduler.
`default_nettype none
module tb;
  import prrs_pkg::*;

  localparam int          TABLE_SLOTS      = 64;
  localparam int          ID_POOL_SIZE     = 80;
  localparam logic [2:0]  FUNC_FIRST_SPARE = 3'd5;
  localparam logic [2:0]  FUNC_MID_SPARE   = 3'd6;
  localparam logic [2:0]  FUNC_LAST_SPARE  = 3'd7;
  localparam logic [4:0]  PRIO_BEST        = 5'd0;
  localparam logic [4:0]  PRIO_WORST       = 5'd31;
  // The settle time leaves headroom over the latency of one operation.
  localparam int          OP_LATENCY       = 2 * TABLE_SLOTS + 4;
  localparam int          SETTLE_CYCLES    = OP_LATENCY + 40;
  localparam int          LONG_HOLD_CYCLES = 900;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_scheduler_enable;

  priority_round_robin_scheduler dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data             (in_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_data            (out_data),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_scheduler_enable(cfg_scheduler_enable)
  );

  // Shadow copy of the task table, kept in step with every accepted operation.
  logic [63:0] shadow_id    [TABLE_SLOTS];
  logic [4:0]  shadow_prio  [TABLE_SLOTS];
  logic [63:0] shadow_stamp [TABLE_SLOTS];
  logic        shadow_live  [TABLE_SLOTS];
  logic [63:0] shadow_next_stamp;
  logic        shadow_enable;

  out_t        pending_answers[$];
  logic [63:0] id_pool[ID_POOL_SIZE];

  int error_count;
  int ops_sent;
  int answers_seen;
  int tx_idle_pct;
  int rx_stall_pct;
  int rx_hold_left;

  // The clock runs with a period of two time units.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // A generous fixed bound that even a slow, heavily stalled run stays under.
  initial begin
    #20000000;
    $display("priority_round_robin_scheduler regression: fail");
    $finish;
  end

  // Scheduler model: these functions mirror the table search of the block.
  function automatic int slot_of_id(input logic [63:0] id);
    for (int i = 0; i < TABLE_SLOTS; i++)
      if (shadow_live[i] && shadow_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int best_slot_now();
    int best;
    best = -1;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (!shadow_live[i]) continue;
      if (best < 0 || shadow_prio[i] < shadow_prio[best] ||
          (shadow_prio[i] == shadow_prio[best] && shadow_stamp[i] < shadow_stamp[best]))
        best = i;
    end
    return best;
  endfunction

  // Applies one operation to the shadow table and returns the answer it gives.
  function automatic out_t schedule_op(input in_t op);
    out_t ans;
    int   s;
    ans.status = 1'b1;
    case (op.func)
      FUNC_ADD: begin
        if (shadow_enable && op.task_id != '0 && slot_of_id(op.task_id) < 0) begin
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (!shadow_live[i]) begin
              shadow_id[i]      = op.task_id;
              shadow_prio[i]    = op.priority_req;
              shadow_stamp[i]   = shadow_next_stamp;
              shadow_next_stamp = shadow_next_stamp + 64'd1;
              shadow_live[i]    = 1'b1;
              ans.status        = 1'b0;
              break;
            end
          end
        end
      end
      FUNC_REMOVE: begin
        s = slot_of_id(op.task_id);
        if (s >= 0) begin
          shadow_live[s] = 1'b0;
          shadow_id[s]   = '0;
          ans.status     = 1'b0;
        end
      end
      FUNC_SETPRI: begin
        s = slot_of_id(op.task_id);
        if (s >= 0) begin
          shadow_prio[s] = op.priority_req;
          ans.status     = 1'b0;
        end
      end
      FUNC_ROTATE: begin
        if (shadow_enable) begin
          s = best_slot_now();
          if (s >= 0) begin
            shadow_stamp[s]   = shadow_next_stamp;
            shadow_next_stamp = shadow_next_stamp + 64'd1;
            ans.status        = 1'b0;
          end
        end
      end
      FUNC_QUERY: ans.status = (best_slot_now() < 0);
      default: ;
    endcase
    s = best_slot_now();
    ans.has_current = (s >= 0);
    ans.current_id  = (s >= 0) ? shadow_id[s] : '0;
    return ans;
  endfunction

  // Result side. The ready line follows the stall rate of the current phase,
  // except during a long hold-off, which this process counts down itself.
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_ready    <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Every completed result transaction is compared with the oldest answer
  // that the shadow table predicted. Signals are read before this edge's
  // updates, so the values seen are those of the closing cycle.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        error_count++;
        $display("%0t: result with nothing pending: status=%0b has=%0b id=%h",
                 $time, out_data.status, out_data.has_current, out_data.current_id);
      end else begin
        want = pending_answers.pop_front();
        if (out_data.status !== want.status) begin
          error_count++;
          $display("%0t: status expected %0b, got %0b", $time, want.status,
                   out_data.status);
        end
        if (out_data.has_current !== want.has_current) begin
          error_count++;
          $display("%0t: has_current expected %0b, got %0b", $time,
                   want.has_current, out_data.has_current);
        end
        if (out_data.current_id !== want.current_id) begin
          error_count++;
          $display("%0t: current_id expected %h, got %h", $time, want.current_id,
                   out_data.current_id);
        end
      end
    end
  end

  // Sends one operation. Before raising valid, the sender may sit idle for a
  // random number of cycles at the phase's idle rate. Valid stays high after
  // acceptance so that back-to-back operations never drop it; wait_for_answers
  // lowers it when a batch ends.
  task automatic send_op(input logic [2:0] func, input logic [63:0] id,
                         input logic [4:0] prio);
    in_t op;
    op.func         = func;
    op.task_id      = id;
    op.priority_req = prio;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (!in_ready);
    pending_answers.push_back(schedule_op(op));
    ops_sent++;
  endtask

  // Stops offering operations and waits until every predicted answer is in.
  task automatic wait_for_answers();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // Writes the enable register. Only called with the block idle.
  task automatic write_enable(input logic value);
    wait_for_answers();
    cfg_valid            <= 1'b1;
    cfg_scheduler_enable <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    shadow_enable = value;
  endtask

  task automatic set_traffic(input int tx_pct, input int rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
  endtask

  // Mostly ids from a small pool so that duplicates, removes and priority
  // changes hit live tasks; a few zero ids and a few fully random ones.
  function automatic logic [63:0] pick_id();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 15) return {$urandom, $urandom};
    return id_pool[$urandom_range(ID_POOL_SIZE - 1)];
  endfunction

  function automatic logic [2:0] pick_func();
    int r;
    r = $urandom_range(99);
    if (r < 35) return FUNC_ADD;
    if (r < 55) return FUNC_REMOVE;
    if (r < 70) return FUNC_SETPRI;
    if (r < 90) return FUNC_ROTATE;
    if (r < 97) return FUNC_QUERY;
    return 3'($urandom_range(FUNC_FIRST_SPARE, FUNC_LAST_SPARE));
  endfunction

  task automatic send_random_ops(input int count);
    for (int n = 0; n < count; n++)
      send_op(pick_func(), pick_id(), 5'($urandom_range(31)));
  endtask

  // Empty table, invalid ids, the id and priority extremes, duplicates,
  // round robin among equal priorities, and the spare function codes.
  task automatic test_directed();
    set_traffic(0, 0);
    send_op(FUNC_QUERY, '0, PRIO_BEST);
    send_op(FUNC_ROTATE, '0, PRIO_BEST);
    send_op(FUNC_REMOVE, 64'd5, PRIO_BEST);
    send_op(FUNC_ADD, '0, PRIO_BEST);
    send_op(FUNC_ADD, '1, PRIO_WORST);
    send_op(FUNC_ADD, '1, PRIO_BEST);
    send_op(FUNC_ADD, 64'd1, PRIO_WORST);
    send_op(FUNC_ADD, 64'h5555_5555_5555_5555, PRIO_WORST);
    send_op(FUNC_ADD, 64'hAAAA_AAAA_AAAA_AAAA, PRIO_WORST);
    send_op(FUNC_ROTATE, '0, PRIO_BEST);
    send_op(FUNC_ROTATE, '0, PRIO_BEST);
    send_op(FUNC_ROTATE, '0, PRIO_BEST);
    send_op(FUNC_SETPRI, 64'h5555_5555_5555_5555, PRIO_BEST);
    send_op(FUNC_SETPRI, '0, PRIO_BEST);
    send_op(FUNC_SETPRI, 64'd99, PRIO_BEST);
    send_op(FUNC_FIRST_SPARE, 64'd1, PRIO_BEST);
    send_op(FUNC_MID_SPARE, 64'd1, PRIO_BEST);
    send_op(FUNC_LAST_SPARE, '1, PRIO_WORST);
    send_op(FUNC_REMOVE, '0, PRIO_BEST);
    send_op(FUNC_REMOVE, 64'h5555_5555_5555_5555, PRIO_BEST);
    send_op(FUNC_QUERY, '0, PRIO_BEST);
    send_op(FUNC_REMOVE, '1, PRIO_BEST);
    send_op(FUNC_REMOVE, 64'd1, PRIO_BEST);
    send_op(FUNC_REMOVE, 64'hAAAA_AAAA_AAAA_AAAA, PRIO_BEST);
    send_op(FUNC_QUERY, '0, PRIO_BEST);
    wait_for_answers();
  endtask

  // Fills every slot, tries one more add and a rotate, then empties the table again.
  task automatic test_full_table();
    set_traffic(0, 0);
    for (int i = 1; i <= TABLE_SLOTS; i++)
      send_op(FUNC_ADD, 64'(i) << 8, 5'($urandom_range(3)));
    send_op(FUNC_ADD, 64'h0123_4567_89AB_CDEF, PRIO_BEST);
    send_op(FUNC_ROTATE, '0, PRIO_BEST);
    for (int i = 1; i <= TABLE_SLOTS; i++)
      send_op(FUNC_REMOVE, 64'(i) << 8, PRIO_BEST);
    wait_for_answers();
  endtask

  // With the scheduler disabled, adds and rotates must fail and change nothing.
  task automatic test_disabled();
    set_traffic(20, 20);
    send_op(FUNC_ADD, 64'd77, PRIO_WORST);
    write_enable(1'b0);
    send_op(FUNC_ADD, 64'd78, PRIO_BEST);
    send_op(FUNC_ROTATE, '0, PRIO_BEST);
    send_random_ops(60);
    write_enable(1'b1);
    send_op(FUNC_ROTATE, '0, PRIO_BEST);
    send_random_ops(20);
    write_enable(1'b0);
    write_enable(1'b1);
    wait_for_answers();
  endtask

  // The result side holds off for a long stretch while operations keep
  // coming, so the block backs up and holds off its input. Afterwards the
  // sender pauses until every answer has come.
  task automatic test_backpressure();
    set_traffic(0, 0);
    rx_hold_left = LONG_HOLD_CYCLES;
    send_random_ops(12);
    wait_for_answers();
  endtask

  // Random traffic in four idling phases, with the enable toggled between.
  task automatic test_random();
    set_traffic(0, 0);
    send_random_ops(500);
    write_enable(1'b0);
    set_traffic(88, 0);
    send_random_ops(100);
    write_enable(1'b1);
    send_random_ops(400);
    set_traffic(0, 88);
    send_random_ops(500);
    set_traffic(26, 26);
    send_random_ops(500);
    wait_for_answers();
  endtask

  initial begin
    rst_n                = 1'b0;
    in_valid             = 1'b0;
    in_data              = '0;
    out_ready            = 1'b0;
    cfg_valid            = 1'b0;
    cfg_scheduler_enable = 1'b1;
    error_count          = 0;
    ops_sent             = 0;
    answers_seen         = 0;
    tx_idle_pct          = 0;
    rx_stall_pct         = 0;
    rx_hold_left         = 0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      shadow_id[i]    = '0;
      shadow_prio[i]  = PRIO_WORST;
      shadow_stamp[i] = '0;
      shadow_live[i]  = 1'b0;
    end
    shadow_next_stamp = '0;
    shadow_enable     = 1'b1;
    for (int i = 0; i < ID_POOL_SIZE; i++)
      id_pool[i] = {$urandom, $urandom} | 64'd1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full_table();
    test_disabled();
    test_backpressure();
    test_random();

    // Let any stray result show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_answers.size() != 0) begin
      error_count++;
      $display("%0t: %0d answers never arrived", $time, pending_answers.size());
    end
    $display("Covered %0d operations and %0d results: all functions, full table,",
             ops_sent, answers_seen);
    $display("enable toggling, long output hold-off and four idling mixes.");
    if (error_count == 0) begin
      $display("priority_round_robin_scheduler regression: pass");
    end else begin
      $display("priority_round_robin_scheduler regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
+incdir+hdl
hdl/prrs_pkg.sv
hdl/prrs_ram.sv
hdl/priority_round_robin_scheduler.sv
tb/sv/tb.sv
